/* rtl/apdp_pkg.sv */
// ----------------------------------------------------------------------------
// apdp_pkg: shared constants for the ATAPI PIO data-phase engine
// Sizes of the stream words, transfer limits, codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package apdp_pkg;

  // transfer limits
  localparam int unsigned BLOCK_BYTES  = 2048;
  localparam int unsigned MAX_BURSTS   = 2048;
  localparam int unsigned BUFFER_BYTES = 32768;

  // largest even byte total that fits the address field
  localparam logic [26:0] TOTAL_MAX   = 27'h7FF_FFFE;
  localparam logic [16:0] LIMIT_CLAMP = 17'h0_FFFE;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 96;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STATUS = 2'd1,
    CMD_WORD   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  // outcome codes
  localparam logic [1:0] OUT_OK    = 2'd0;
  localparam logic [1:0] OUT_ERROR = 2'd1;
  localparam logic [1:0] OUT_CHECK = 2'd2;

  // ata status bits
  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_DF  = 8'h20;

  // one result word, before packing
  typedef struct packed {
    logic [15:0] delivered_bytes;
    logic [1:0]  outcome;
    logic        done_res;
    logic [15:0] words_left;
    logic [15:0] store_data;
    logic [26:0] store_addr;
    logic        store_high;
    logic        store_low;
    logic [15:0] burst_limit;
  } result_t;

endpackage

`default_nettype wire

/* rtl/atapi_pio_data_phase_top.sv */
// Path: an accepted word is held in the input register; the command state and
// result are worked out in a single pass and shown from the result register.
// Throughput: one word per cycle unless out_tready stalls the result register;
// the input register moves whenever the result register is empty or taken.
// Reset (rst_n low, synchronous) empties both registers and sets the command
// engine idle with all counters cleared.
// ----------------------------------------------------------------------------
// atapi_pio_data_phase_top: host-side PIO data phase of an ATAPI packet command
// Computes the byte-count limit, runs the burst/status sequence and issues
// buffer store requests for each data word.
// ----------------------------------------------------------------------------
`default_nettype none

module atapi_pio_data_phase_top #(
  parameter int unsigned BLOCK_BYTES  = apdp_pkg::BLOCK_BYTES,
  parameter int unsigned MAX_BURSTS   = apdp_pkg::MAX_BURSTS,
  parameter int unsigned BUFFER_BYTES = apdp_pkg::BUFFER_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // buffer_size, status_byte, wait_timed_out, burst_bytes, data_word, zero pad
  input  wire logic [apdp_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic [apdp_pkg::IN_USER_W-1:0]  in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // burst_limit, store_low, store_high, store_addr, store_data, words_left,
  // done_res, outcome, delivered_bytes
  output logic [apdp_pkg::OUT_DATA_W-1:0]      out_tdata
);

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_STATUS = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam logic [16:0] BUF_MAX   = 17'(BUFFER_BYTES);
  localparam logic [16:0] BLOCK_MIN = 17'(BLOCK_BYTES);
  localparam logic [11:0] BURST_CAP = 12'(MAX_BURSTS);

  // input register
  logic        in_valid_r;
  logic [1:0]  cmd_r;
  logic [15:0] size_r;
  logic [7:0]  status_r;
  logic        tmo_r;
  logic [15:0] nbytes_r;
  logic [15:0] word_r;

  // result register
  logic                 out_valid_r;
  apdp_pkg::result_t    res_r;
  apdp_pkg::result_t    res_nxt;

  // command state
  logic [1:0]  phase_r,         phase_nxt;
  logic [15:0] buffer_limit_r,  buffer_limit_nxt;
  logic [26:0] total_bytes_r,   total_bytes_nxt;
  logic [11:0] burst_count_r,   burst_count_nxt;
  logic [15:0] words_pending_r, words_pending_nxt;

  logic        advance;
  logic        load_in;

  // result stage moves when empty or taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign load_in   = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (load_in) begin
      cmd_r    <= in_tuser;
      size_r   <= in_tdata[15:0];
      status_r <= in_tdata[23:16];
      tmo_r    <= in_tdata[24];
      nbytes_r <= in_tdata[40:25];
      word_r   <= in_tdata[56:41];
    end
  end

  // single pass: next state and result for the registered word
  always_comb begin
    logic [16:0] size_sat;
    logic [16:0] lim;
    logic [16:0] half;
    logic [27:0] total_p1;
    logic        done;

    phase_nxt         = phase_r;
    buffer_limit_nxt  = buffer_limit_r;
    total_bytes_nxt   = total_bytes_r;
    burst_count_nxt   = burst_count_r;
    words_pending_nxt = words_pending_r;
    res_nxt           = '0;
    done              = 1'b0;

    size_sat = ({1'b0, size_r} > BUF_MAX) ? BUF_MAX : {1'b0, size_r};
    lim      = (size_sat > apdp_pkg::LIMIT_CLAMP) ? apdp_pkg::LIMIT_CLAMP : size_sat;
    lim      = (lim < BLOCK_MIN) ? BLOCK_MIN : lim;
    half     = ({1'b0, nbytes_r} + 17'd1) >> 1;
    total_p1 = {1'b0, total_bytes_r} + 28'd1;

    if (cmd_r == apdp_pkg::CMD_START) begin
      res_nxt.burst_limit = {lim[15:1], 1'b0};
      buffer_limit_nxt    = size_sat[15:0];
      total_bytes_nxt     = '0;
      burst_count_nxt     = '0;
      words_pending_nxt   = '0;
      phase_nxt           = PH_STATUS;
    end else if (cmd_r == apdp_pkg::CMD_STATUS && phase_r == PH_STATUS) begin
      if (burst_count_r >= BURST_CAP) begin
        done            = 1'b1;
        res_nxt.outcome = apdp_pkg::OUT_ERROR;
      end else begin
        burst_count_nxt = burst_count_r + 12'd1;
        if (tmo_r) begin
          done            = 1'b1;
          res_nxt.outcome = apdp_pkg::OUT_ERROR;
        end else if ((status_r & (apdp_pkg::ST_ERR | apdp_pkg::ST_DF)) != 8'h00) begin
          done            = 1'b1;
          res_nxt.outcome = apdp_pkg::OUT_CHECK;
        end else if ((status_r & apdp_pkg::ST_DRQ) == 8'h00 || nbytes_r == 16'd0) begin
          done            = 1'b1;
          res_nxt.outcome = apdp_pkg::OUT_OK;
          res_nxt.delivered_bytes = (total_bytes_r > {11'd0, buffer_limit_r}) ?
                                    buffer_limit_r : total_bytes_r[15:0];
        end else begin
          words_pending_nxt = half[15:0];
          phase_nxt         = PH_DATA;
        end
      end
      if (done) begin
        phase_nxt         = PH_IDLE;
        words_pending_nxt = '0;
      end
    end else if (cmd_r == apdp_pkg::CMD_WORD && phase_r == PH_DATA &&
                 words_pending_r != 16'd0) begin
      res_nxt.store_low  = total_bytes_r < {11'd0, buffer_limit_r};
      res_nxt.store_high = total_p1 < {12'd0, buffer_limit_r};
      res_nxt.store_addr = total_bytes_r;
      res_nxt.store_data = word_r;
      total_bytes_nxt    = (total_bytes_r >= apdp_pkg::TOTAL_MAX) ?
                           apdp_pkg::TOTAL_MAX : total_bytes_r + 27'd2;
      words_pending_nxt  = words_pending_r - 16'd1;
      if (words_pending_nxt == 16'd0) begin
        phase_nxt = PH_STATUS;
      end
    end

    res_nxt.done_res   = done;
    res_nxt.words_left = words_pending_nxt;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      phase_r         <= PH_IDLE;
      buffer_limit_r  <= '0;
      total_bytes_r   <= '0;
      burst_count_r   <= '0;
      words_pending_r <= '0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        phase_r         <= phase_nxt;
        buffer_limit_r  <= buffer_limit_nxt;
        total_bytes_r   <= total_bytes_nxt;
        burst_count_r   <= burst_count_nxt;
        words_pending_r <= words_pending_nxt;
      end
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

`ifndef ASSERT_OFF
  // a data phase always has words outstanding
  a_data_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> words_pending_r != 16'd0)
    else $error("data phase with no words pending");

  // a finished command leaves no burst open
  a_done_clears_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> res_r.words_left == 16'd0)
    else $error("command ended with words still pending");

  // the high byte is never kept when the low byte is dropped
  a_store_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.store_high |-> res_r.store_low)
    else $error("high byte stored without low byte");

  // a delivered count only comes with a clean end
  a_delivered_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.delivered_bytes != 16'd0 |->
      res_r.done_res && res_r.outcome == apdp_pkg::OUT_OK)
    else $error("delivered count without ok end");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
